### rtl/tsa_pkg.sv
// shared types and constants for the touch slot allocator
package tsa_pkg;

   localparam int OPCODE_W   = 3;
   localparam int OWNER_IN_W = 8;
   localparam int SLOT_IN_W  = 5;
   localparam int STATUS_W   = 2;
   localparam int SLOT_OUT_W = 4;
   localparam int MASK_W     = 10;
   localparam int TICKS_W    = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int OWNER_IDS  = 2 ** OWNER_IN_W;

   localparam logic [MASK_W-1:0]  MASK_RESET  = 10'd519;
   localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd50;

   localparam logic [OPCODE_W-1:0] OP_TICK  = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_ALLOC = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_REL   = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_QUERY = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_CLEAR = 3'd4;

   localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_FREE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MASK  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TICKS = 1'd1;

   typedef struct packed {
      logic load;
      logic tick;
      logic alloc;
      logic rel;
      logic query;
      logic clear;
      logic mask_we;
      logic ticks_we;
   } cmd_type;

endpackage

### rtl/tsa_req_if.sv
// request channel: one operation item
interface tsa_req_if;
   logic                                valid;
   logic                                ready;
   logic [tsa_pkg::OPCODE_W-1:0]        opcode;
   logic [tsa_pkg::OWNER_IN_W-1:0]      owner;
   logic signed [tsa_pkg::SLOT_IN_W-1:0] slot_in;
   logic                                start_cooldown;

   modport source (output valid, opcode, owner, slot_in, start_cooldown, input ready);
   modport sink   (input valid, opcode, owner, slot_in, start_cooldown, output ready);
endinterface

### rtl/tsa_rsp_if.sv
// response channel: one result item
interface tsa_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [tsa_pkg::STATUS_W-1:0]   status;
   logic [tsa_pkg::SLOT_OUT_W-1:0] slot_out;
   logic                           owned;

   modport source (output valid, status, slot_out, owned, input ready);
   modport sink   (input valid, status, slot_out, owned, output ready);
endinterface

### rtl/tsa_ctrl.sv
// controller: handshake state machine and opcode decode
module tsa_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic [tsa_pkg::OPCODE_W-1:0]    req_opcode,
   output logic                            req_ready,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic                            csr_we,
   input  logic [tsa_pkg::CSR_IDX_W-1:0]   csr_index,
   output tsa_pkg::cmd_type                cmd
);

   typedef enum logic {EMPTY, FULL} state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = !reset && (state_ff == EMPTY || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = state_ff == FULL;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         EMPTY: begin
            if (accept) state_in = FULL;
         end
         FULL: begin
            if (rsp_ready && !accept) state_in = EMPTY;
         end
         default: state_in = EMPTY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EMPTY;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd          = '0;
      cmd.load     = accept;
      cmd.tick     = accept && req_opcode == tsa_pkg::OP_TICK;
      cmd.alloc    = accept && req_opcode == tsa_pkg::OP_ALLOC;
      cmd.rel      = accept && req_opcode == tsa_pkg::OP_REL;
      cmd.query    = accept && req_opcode == tsa_pkg::OP_QUERY;
      cmd.clear    = accept && req_opcode == tsa_pkg::OP_CLEAR;
      cmd.mask_we  = csr_we && csr_index == tsa_pkg::CSR_MASK;
      cmd.ticks_we = csr_we && csr_index == tsa_pkg::CSR_TICKS;
   end

endmodule

### rtl/tsa_datapath.sv
// datapath: slot table, config registers, free slot search and result register
module tsa_datapath #(
   parameter int SLOT_COUNT  = 10,
   parameter int OWNER_COUNT = 256
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tsa_pkg::cmd_type                      cmd,
   input  logic [tsa_pkg::OWNER_IN_W-1:0]        owner,
   input  logic signed [tsa_pkg::SLOT_IN_W-1:0]  slot_in,
   input  logic                                  start_cooldown,
   input  logic [tsa_pkg::CSR_DATA_W-1:0]        csr_data,
   output logic [tsa_pkg::STATUS_W-1:0]          status,
   output logic [tsa_pkg::SLOT_OUT_W-1:0]        slot_out,
   output logic                                  owned
);

   localparam int SLOT_W  = $clog2(SLOT_COUNT);
   localparam int OWNER_W = (OWNER_COUNT >= tsa_pkg::OWNER_IDS) ?
                            tsa_pkg::OWNER_IN_W : $clog2(OWNER_COUNT);
   localparam int EXT_W   = (SLOT_COUNT > tsa_pkg::MASK_W) ? SLOT_COUNT : tsa_pkg::MASK_W;

   typedef logic [OWNER_W-1:0] who_tbl_type [tsa_pkg::OWNER_IDS];

   function automatic who_tbl_type build_who_tbl();
      who_tbl_type t;
      for (int i = 0; i < tsa_pkg::OWNER_IDS; i++) begin
         t[i] = OWNER_W'(i % OWNER_COUNT);
      end
      return t;
   endfunction

   localparam who_tbl_type WHO_TBL = build_who_tbl();

   logic                            busy_ff  [SLOT_COUNT];
   logic                            busy_in  [SLOT_COUNT];
   logic [OWNER_W-1:0]              owner_ff [SLOT_COUNT];
   logic [OWNER_W-1:0]              owner_in [SLOT_COUNT];
   logic [tsa_pkg::TICKS_W-1:0]     cool_ff  [SLOT_COUNT];
   logic [tsa_pkg::TICKS_W-1:0]     cool_in  [SLOT_COUNT];
   logic [tsa_pkg::MASK_W-1:0]      mask_ff;
   logic [tsa_pkg::TICKS_W-1:0]     ticks_ff;
   logic [tsa_pkg::STATUS_W-1:0]    status_ff, status_in;
   logic [tsa_pkg::SLOT_OUT_W-1:0]  slot_out_ff, slot_out_in;
   logic                            owned_ff, owned_in;

   logic [EXT_W-1:0]                mask_ext;
   logic [SLOT_COUNT-1:0]           eligible;
   logic                            found;
   logic [SLOT_W-1:0]               pick;
   logic [OWNER_W-1:0]              who;
   logic                            slot_ok;
   logic [SLOT_W-1:0]               sel;
   logic                            holder;

   assign who      = WHO_TBL[owner];
   assign mask_ext = EXT_W'(mask_ff);
   assign slot_ok  = !slot_in[tsa_pkg::SLOT_IN_W-1] &&
                     ({1'b0, slot_in[tsa_pkg::SLOT_IN_W-2:0]} <
                      tsa_pkg::SLOT_IN_W'(SLOT_COUNT));
   assign sel      = slot_in[SLOT_W-1:0];
   assign holder   = slot_ok && busy_ff[sel] && owner_ff[sel] == who;

   // lowest eligible slot wins
   always_comb begin
      found = 1'b0;
      pick  = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         eligible[i] = !mask_ext[i] && !busy_ff[i] && cool_ff[i] == '0;
         if (eligible[i]) begin
            found = 1'b1;
            pick  = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         busy_in[i]  = busy_ff[i];
         owner_in[i] = owner_ff[i];
         cool_in[i]  = cool_ff[i];
         if (cmd.tick && cool_ff[i] != '0) cool_in[i] = cool_ff[i] - 1'b1;
         if (cmd.clear) begin
            busy_in[i]  = 1'b0;
            owner_in[i] = '0;
            cool_in[i]  = '0;
         end
      end
      status_in   = tsa_pkg::ST_DONE;
      slot_out_in = '0;
      owned_in    = 1'b0;
      if (cmd.alloc) begin
         if (found) begin
            busy_in[pick]  = 1'b1;
            owner_in[pick] = who;
            slot_out_in    = tsa_pkg::SLOT_OUT_W'(pick);
         end else begin
            status_in = tsa_pkg::ST_NO_FREE;
         end
      end
      if (cmd.rel) begin
         if (holder) begin
            busy_in[sel]  = 1'b0;
            owner_in[sel] = '0;
            if (start_cooldown) cool_in[sel] = ticks_ff;
         end else begin
            status_in = tsa_pkg::ST_INVALID;
         end
      end
      if (cmd.query) begin
         if (slot_ok) owned_in = holder;
         else status_in = tsa_pkg::ST_INVALID;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            busy_ff[i]  <= 1'b0;
            owner_ff[i] <= '0;
            cool_ff[i]  <= '0;
         end
         mask_ff  <= tsa_pkg::MASK_RESET;
         ticks_ff <= tsa_pkg::TICKS_RESET;
      end else begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            busy_ff[i]  <= busy_in[i];
            owner_ff[i] <= owner_in[i];
            cool_ff[i]  <= cool_in[i];
         end
         if (cmd.mask_we)  mask_ff  <= csr_data[tsa_pkg::MASK_W-1:0];
         if (cmd.ticks_we) ticks_ff <= csr_data[tsa_pkg::TICKS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         status_ff   <= status_in;
         slot_out_ff <= slot_out_in;
         owned_ff    <= owned_in;
      end
   end

   assign status   = status_ff;
   assign slot_out = slot_out_ff;
   assign owned    = owned_ff;

endmodule

### rtl/touch_slot_allocator_cooldown.sv
// top level of the touch slot allocator with reuse cooldown
//
//   channel | direction | handshake           | payload
//   req     | in        | valid / ready       | opcode, owner, slot_in, start_cooldown
//   rsp     | out       | valid / ready       | status, slot_out, owned
//   csr     | in        | csr_we, no stall    | csr_index, csr_data
//
// one item per cycle while rsp is not stalled: an item is executed at its accept edge and its result
// shows in the rsp register on the next cycle; the free slot search over all slots is
// combinational, so the slot table updates at that same accept edge
// req.ready is high outside reset while rsp is empty or being taken in the same cycle
// reset is synchronous and leaves every slot free with no cooldown
module touch_slot_allocator_cooldown #(
   parameter int SLOT_COUNT  = 10,
   parameter int OWNER_COUNT = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   tsa_req_if.sink                           req,
   tsa_rsp_if.source                         rsp,
   input  logic                              csr_we,
   input  logic [tsa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tsa_pkg::CSR_DATA_W-1:0]    csr_data
);

   tsa_pkg::cmd_type cmd;

   tsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req.valid),
      .req_opcode (req.opcode),
      .req_ready  (req.ready),
      .rsp_valid  (rsp.valid),
      .rsp_ready  (rsp.ready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .cmd        (cmd)
   );

   tsa_datapath #(
      .SLOT_COUNT  (SLOT_COUNT),
      .OWNER_COUNT (OWNER_COUNT)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .owner          (req.owner),
      .slot_in        (req.slot_in),
      .start_cooldown (req.start_cooldown),
      .csr_data       (csr_data),
      .status         (rsp.status),
      .slot_out       (rsp.slot_out),
      .owned          (rsp.owned)
   );

endmodule

### rtl/tsa_checker.sv
// port level checks for the touch slot allocator
module tsa_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [tsa_pkg::STATUS_W-1:0]    rsp_status,
   input logic [tsa_pkg::SLOT_OUT_W-1:0]  rsp_slot_out,
   input logic                            rsp_owned
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending right after reset");

   a_accept_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted item gave no result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_fields_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != tsa_pkg::ST_DONE |-> rsp_slot_out == '0 && !rsp_owned &&
      (rsp_status == tsa_pkg::ST_NO_FREE || rsp_status == tsa_pkg::ST_INVALID))
      else $error("bad result fields on failed item");

endmodule

bind touch_slot_allocator_cooldown tsa_checker u_tsa_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req.valid),
   .req_ready    (req.ready),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_status   (rsp.status),
   .rsp_slot_out (rsp.slot_out),
   .rsp_owned    (rsp.owned)
);

### verif/testbench.sv
// self-checking testbench for the touch slot allocator with reuse cooldown
module testbench;

   localparam int SLOT_COUNT     = 10;
   localparam int DIRECTED_COUNT = 25;
   localparam int PHASE_COUNT    = 7;
   localparam int MAX_WAIT       = 14;
   localparam int HOLD_AT        = 300;
   localparam int HOLD_CYCLES    = 300;
   localparam int QUIET_LIMIT    = 1000;
   localparam int DRAIN_CYCLES   = 4;

   localparam logic [tsa_pkg::OPCODE_W-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [tsa_pkg::OPCODE_W-1:0] OP_SPARE_LAST  = 3'd7;

   typedef struct packed {
      logic [tsa_pkg::OPCODE_W-1:0]   opcode;
      logic [tsa_pkg::OWNER_IN_W-1:0] owner;
      logic [tsa_pkg::SLOT_IN_W-1:0]  slot_in;
      logic                           start_cooldown;
   } slot_op_type;

   typedef struct packed {
      logic [tsa_pkg::STATUS_W-1:0]   status;
      logic [tsa_pkg::SLOT_OUT_W-1:0] slot_out;
      logic                           owned;
   } slot_result_type;

   typedef struct packed {
      slot_op_type     op;
      logic            typed;
      slot_result_type res;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                           csr_we;
   logic [tsa_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [tsa_pkg::CSR_DATA_W-1:0] csr_data;

   tsa_req_if req_ch ();
   tsa_rsp_if rsp_ch ();

   touch_slot_allocator_cooldown dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predicted copy of the slot table and its settings
   logic [tsa_pkg::MASK_W-1:0]     mask_cfg;
   logic [tsa_pkg::TICKS_W-1:0]    ticks_cfg;
   logic                           slot_taken  [SLOT_COUNT];
   logic [tsa_pkg::OWNER_IN_W-1:0] slot_holder [SLOT_COUNT];
   logic [tsa_pkg::TICKS_W-1:0]    cool_left   [SLOT_COUNT];

   slot_result_type pending_results [$];
   directed_row_type directed_rows [DIRECTED_COUNT];
   logic [tsa_pkg::MASK_W-1:0]  phase_mask  [PHASE_COUNT];
   logic [tsa_pkg::TICKS_W-1:0] phase_ticks [PHASE_COUNT];
   int                          phase_items [PHASE_COUNT];

   bit send_steady;
   bit recv_steady;
   int items_sent;
   int results_seen;
   int mismatches;
   int grants;
   int pool_empty;
   int rejects;
   int owned_hits;

   function automatic void clear_table();
      for (int i = 0; i < SLOT_COUNT; i++) begin
         slot_taken[i]  = 1'b0;
         slot_holder[i] = '0;
         cool_left[i]   = '0;
      end
   endfunction

   function automatic slot_result_type slot_table_step(slot_op_type op);
      slot_result_type res;
      int slot_num;
      bit in_range;
      bit found;
      res      = '{tsa_pkg::ST_DONE, '0, 1'b0};
      slot_num = int'($signed(op.slot_in));
      in_range = slot_num >= 0 && slot_num < SLOT_COUNT;
      found    = 1'b0;
      case (op.opcode)
         tsa_pkg::OP_TICK: begin
            for (int i = 0; i < SLOT_COUNT; i++)
               if (cool_left[i] != '0) cool_left[i] = cool_left[i] - 1'b1;
         end
         tsa_pkg::OP_ALLOC: begin
            res.status = tsa_pkg::ST_NO_FREE;
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (!found && !(i < tsa_pkg::MASK_W && mask_cfg[i]) && !slot_taken[i]
                     && cool_left[i] == '0) begin
                  found          = 1'b1;
                  slot_taken[i]  = 1'b1;
                  slot_holder[i] = op.owner;
                  res.status     = tsa_pkg::ST_DONE;
                  res.slot_out   = tsa_pkg::SLOT_OUT_W'(i);
               end
            end
         end
         tsa_pkg::OP_REL: begin
            if (!in_range || !slot_taken[slot_num] || slot_holder[slot_num] != op.owner) begin
               res.status = tsa_pkg::ST_INVALID;
            end else begin
               if (op.start_cooldown) cool_left[slot_num] = ticks_cfg;
               slot_taken[slot_num]  = 1'b0;
               slot_holder[slot_num] = '0;
            end
         end
         tsa_pkg::OP_QUERY: begin
            if (!in_range) res.status = tsa_pkg::ST_INVALID;
            else res.owned = slot_taken[slot_num] && slot_holder[slot_num] == op.owner;
         end
         tsa_pkg::OP_CLEAR: clear_table();
         default: ;
      endcase
      return res;
   endfunction

   // steady stretches with no waiting, otherwise a random wait per item
   function automatic int draw_wait(ref bit steady);
      if ($urandom_range(0, 49) == 0) steady = !steady;
      return steady ? 0 : int'($urandom_range(0, MAX_WAIT));
   endfunction

   // mostly well-formed traffic aimed at slots that are actually held
   function automatic slot_op_type random_op();
      slot_op_type op;
      int held [$];
      int pick;
      int roll;
      op.owner          = tsa_pkg::OWNER_IN_W'($urandom_range(0, tsa_pkg::OWNER_IDS - 1));
      op.slot_in        = tsa_pkg::SLOT_IN_W'($urandom_range(0, 2 ** tsa_pkg::SLOT_IN_W - 1));
      op.start_cooldown = 1'($urandom_range(0, 1));
      for (int i = 0; i < SLOT_COUNT; i++)
         if (slot_taken[i]) held = {held, i};
      pick = held.size() > 0 ? held[$urandom_range(0, held.size() - 1)] : 0;
      roll = $urandom_range(0, 99);
      if (roll < 28) begin
         op.opcode = tsa_pkg::OP_ALLOC;
      end else if (roll < 55 || roll < 72) begin
         op.opcode = roll < 55 ? tsa_pkg::OP_REL : tsa_pkg::OP_QUERY;
         if (held.size() > 0 && $urandom_range(0, 9) < 7) begin
            op.slot_in = tsa_pkg::SLOT_IN_W'(pick);
            op.owner   = slot_holder[pick];
            if ($urandom_range(0, 7) == 0)
               op.owner = op.owner ^ (tsa_pkg::OWNER_IN_W'(1)
                          << $urandom_range(0, tsa_pkg::OWNER_IN_W - 1));
         end
      end else if (roll < 94) begin
         op.opcode = tsa_pkg::OP_TICK;
      end else if (roll < 97) begin
         op.opcode = tsa_pkg::OP_CLEAR;
      end else begin
         op.opcode = tsa_pkg::OPCODE_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      end
      return op;
   endfunction

   task automatic offer_item(input slot_op_type op, input logic typed,
                             input slot_result_type typed_res);
      int gap;
      slot_result_type due;
      gap = draw_wait(send_steady);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.opcode         <= op.opcode;
      req_ch.owner          <= op.owner;
      req_ch.slot_in        <= op.slot_in;
      req_ch.start_cooldown <= op.start_cooldown;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      due = slot_table_step(op);
      if (typed) due = typed_res;
      pending_results = {pending_results, due};
      items_sent++;
      if (op.opcode == tsa_pkg::OP_ALLOC && due.status == tsa_pkg::ST_DONE) grants++;
      if (due.status == tsa_pkg::ST_NO_FREE) pool_empty++;
      if (due.status == tsa_pkg::ST_INVALID) rejects++;
      if (due.owned) owned_hits++;
   endtask

   // registers change only with the block drained
   task automatic load_settings(input logic [tsa_pkg::MASK_W-1:0] mask,
                                input logic [tsa_pkg::TICKS_W-1:0] ticks);
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= tsa_pkg::CSR_MASK;
      csr_data  <= tsa_pkg::CSR_DATA_W'(mask);
      @(posedge clock);
      csr_index <= tsa_pkg::CSR_TICKS;
      csr_data  <= tsa_pkg::CSR_DATA_W'(ticks);
      @(posedge clock);
      csr_we    <= 1'b0;
      mask_cfg  = mask;
      ticks_cfg = ticks;
   endtask

   initial begin : stimulus
      slot_op_type op;
      req_ch.valid          <= 1'b0;
      req_ch.opcode         <= tsa_pkg::OP_TICK;
      req_ch.owner          <= '0;
      req_ch.slot_in        <= '0;
      req_ch.start_cooldown <= 1'b0;
      rsp_ch.ready          <= 1'b0;
      csr_we                <= 1'b0;
      csr_index             <= tsa_pkg::CSR_MASK;
      csr_data              <= '0;
      mask_cfg  = tsa_pkg::MASK_RESET;
      ticks_cfg = tsa_pkg::TICKS_RESET;
      clear_table();

      // reset settings reserve slots 0, 1, 2 and 9; slot 5'h1F is -1, 5'h10 is -16
      directed_rows = '{
         '{'{tsa_pkg::OP_QUERY, 8'h00, 5'd0,  1'b0}, 1'b1, '{tsa_pkg::ST_DONE,    4'd0, 1'b0}},
         '{'{tsa_pkg::OP_ALLOC, 8'hFF, 5'd0,  1'b0}, 1'b1, '{tsa_pkg::ST_DONE,    4'd3, 1'b0}},
         '{'{tsa_pkg::OP_ALLOC, 8'h00, 5'd0,  1'b0}, 1'b1, '{tsa_pkg::ST_DONE,    4'd4, 1'b0}},
         '{'{tsa_pkg::OP_QUERY, 8'hFF, 5'd3,  1'b0}, 1'b1, '{tsa_pkg::ST_DONE,    4'd0, 1'b1}},
         '{'{tsa_pkg::OP_QUERY, 8'h00, 5'd3,  1'b0}, 1'b1, '{tsa_pkg::ST_DONE,    4'd0, 1'b0}},
         '{'{tsa_pkg::OP_QUERY, 8'h00, 5'h1F, 1'b0}, 1'b1, '{tsa_pkg::ST_INVALID, 4'd0, 1'b0}},
         '{'{tsa_pkg::OP_QUERY, 8'hFF, 5'd10, 1'b0}, 1'b1, '{tsa_pkg::ST_INVALID, 4'd0, 1'b0}},
         '{'{tsa_pkg::OP_QUERY, 8'h00, 5'h10, 1'b0}, 1'b1, '{tsa_pkg::ST_INVALID, 4'd0, 1'b0}},
         '{'{tsa_pkg::OP_QUERY, 8'h00, 5'd15, 1'b0}, 1'b1, '{tsa_pkg::ST_INVALID, 4'd0, 1'b0}},
         '{'{tsa_pkg::OP_REL,   8'h00, 5'd3,  1'b1}, 1'b1, '{tsa_pkg::ST_INVALID, 4'd0, 1'b0}},
         '{'{tsa_pkg::OP_REL,   8'hFF, 5'd3,  1'b1}, 1'b1, '{tsa_pkg::ST_DONE,    4'd0, 1'b0}},
         '{'{tsa_pkg::OP_REL,   8'hFF, 5'd3,  1'b0}, 1'b1, '{tsa_pkg::ST_INVALID, 4'd0, 1'b0}},
         '{'{tsa_pkg::OP_ALLOC, 8'h07, 5'd0,  1'b0}, 1'b0, '{tsa_pkg::ST_DONE,    4'd0, 1'b0}},
         '{'{tsa_pkg::OP_REL,   8'h00, 5'd4,  1'b0}, 1'b0, '{tsa_pkg::ST_DONE,    4'd0, 1'b0}},
         '{'{tsa_pkg::OP_ALLOC, 8'h01, 5'd0,  1'b0}, 1'b0, '{tsa_pkg::ST_DONE,    4'd0, 1'b0}},
         '{'{tsa_pkg::OP_TICK,  8'hFF, 5'h1F, 1'b1}, 1'b1, '{tsa_pkg::ST_DONE,    4'd0, 1'b0}},
         '{'{OP_SPARE_FIRST,    8'hFF, 5'd15, 1'b1}, 1'b1, '{tsa_pkg::ST_DONE,    4'd0, 1'b0}},
         '{'{OP_SPARE_LAST,     8'h00, 5'd0,  1'b0}, 1'b1, '{tsa_pkg::ST_DONE,    4'd0, 1'b0}},
         '{'{tsa_pkg::OP_REL,   8'hAA, 5'h1F, 1'b1}, 1'b1, '{tsa_pkg::ST_INVALID, 4'd0, 1'b0}},
         '{'{tsa_pkg::OP_ALLOC, 8'h80, 5'd0,  1'b0}, 1'b0, '{tsa_pkg::ST_DONE,    4'd0, 1'b0}},
         '{'{tsa_pkg::OP_ALLOC, 8'h55, 5'd0,  1'b0}, 1'b0, '{tsa_pkg::ST_DONE,    4'd0, 1'b0}},
         '{'{tsa_pkg::OP_ALLOC, 8'h2A, 5'd0,  1'b0}, 1'b0, '{tsa_pkg::ST_DONE,    4'd0, 1'b0}},
         '{'{tsa_pkg::OP_ALLOC, 8'h01, 5'd0,  1'b0}, 1'b1, '{tsa_pkg::ST_NO_FREE, 4'd0, 1'b0}},
         '{'{tsa_pkg::OP_CLEAR, 8'hFF, 5'h1F, 1'b1}, 1'b1, '{tsa_pkg::ST_DONE,    4'd0, 1'b0}},
         '{'{tsa_pkg::OP_ALLOC, 8'h0F, 5'd0,  1'b0}, 1'b1, '{tsa_pkg::ST_DONE,    4'd3, 1'b0}}
      };

      phase_mask  = '{10'd0, 10'd1023, 10'd0, 10'h155,
                      tsa_pkg::MASK_W'($urandom_range(0, 1023)),
                      10'h3F0, tsa_pkg::MASK_RESET};
      phase_ticks = '{16'd0, 16'd65535, 16'd65535, 16'd2,
                      tsa_pkg::TICKS_W'($urandom_range(1, 8)),
                      16'd5, tsa_pkg::TICKS_RESET};
      phase_items = '{200, 120, 200, 220, 220, 220, 250};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIRECTED_COUNT; r++)
         offer_item(directed_rows[r].op, directed_rows[r].typed, directed_rows[r].res);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         load_settings(phase_mask[p], phase_ticks[p]);
         for (int n = 0; n < phase_items[p]; n++) begin
            op = random_op();
            offer_item(op, 1'b0, '0);
         end
      end

      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d items over %0d register settings, %0d results checked",
               items_sent, PHASE_COUNT + 1, results_seen);
      $display("%0d grants, %0d with no slot free, %0d rejected, %0d ownership hits",
               grants, pool_empty, rejects, owned_hits);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin : result_sink
      slot_result_type due;
      int stall;
      bit held_long;
      held_long = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (results_seen == HOLD_AT && !held_long) begin
            // long back-pressure so the result register fills and req stalls
            held_long = 1'b1;
            stall     = HOLD_CYCLES;
         end else begin
            stall = draw_wait(recv_steady);
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         results_seen++;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected item, status %0d slot_out %0d owned %0d",
                     $time, rsp_ch.status, rsp_ch.slot_out, rsp_ch.owned);
            mismatches++;
         end else begin
            due = pending_results.pop_front();
            if (rsp_ch.status !== due.status) begin
               $display("%0t: status expected %0d actual %0d", $time, due.status, rsp_ch.status);
               mismatches++;
            end
            if (rsp_ch.slot_out !== due.slot_out) begin
               $display("%0t: slot_out expected %0d actual %0d",
                        $time, due.slot_out, rsp_ch.slot_out);
               mismatches++;
            end
            if (rsp_ch.owned !== due.owned) begin
               $display("%0t: owned expected %0d actual %0d", $time, due.owned, rsp_ch.owned);
               mismatches++;
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (reset) @(posedge clock);
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
         else quiet++;
      end
      $display("%0t: no item moved for %0d cycles, %0d results outstanding",
               $time, QUIET_LIMIT, pending_results.size());
      $display("Some tests failed");
      $finish;
   end

endmodule

### files.f
rtl/tsa_pkg.sv
rtl/tsa_req_if.sv
rtl/tsa_rsp_if.sv
rtl/tsa_ctrl.sv
rtl/tsa_datapath.sv
rtl/touch_slot_allocator_cooldown.sv
rtl/tsa_checker.sv
verif/testbench.sv
